/* rtl/core/wgd_pkg.sv */
// shared types, constants and register codes of the wrist gesture detector
package wgd_pkg;

	localparam int SAMPLE_W        = 16;
	localparam int THRESH_W        = 16;
	localparam int TREND_W         = 4;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 16;
	localparam int WINDOW_LEN_DEF  = 14;
	localparam int AVG_TAPS_DEF    = 5;

	localparam logic [THRESH_W-1:0] RANGE_THRESHOLD_RST = THRESH_W'(4000);
	localparam logic [TREND_W-1:0]  MIN_TREND_COUNT_RST = TREND_W'(9);
	localparam logic                DIRECTION_RST       = 1'b0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RANGE_THRESHOLD = 2'd0,
		REG_MIN_TREND_COUNT = 2'd1,
		REG_DIRECTION       = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [THRESH_W-1:0] range_threshold;
		logic [TREND_W-1:0]  min_trend_count;
		logic                direction;
	} cfg_t;

endpackage

/* rtl/core/wgd_average.sv */
// negation and moving average of the incoming samples
module wgd_average import wgd_pkg::*; #(
	parameter int AVG_TAPS = AVG_TAPS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       shift,
	output logic signed [SAMPLE_W-1:0] mean
);

	localparam int LOG_TAPS = $clog2(AVG_TAPS);
	localparam int SUM_W    = SAMPLE_W + LOG_TAPS;
	localparam int K        = SUM_W + LOG_TAPS;
	localparam int RECIP    = ((1 << K) + AVG_TAPS - 1) / AVG_TAPS;
	localparam int PROD_W   = SUM_W + K + 1;

	logic signed [SAMPLE_W-1:0] neg;
	logic signed [SUM_W-1:0]    sum;
	logic                       sum_neg;
	logic [SUM_W-1:0]           mag;
	logic [PROD_W-1:0]          prod;
	logic [SAMPLE_W-1:0]        quot;

	// negate with wrap, most negative value maps to itself
	assign neg = SAMPLE_W'(-sample);

	generate
		if (AVG_TAPS > 1) begin : g_hist
			logic signed [SAMPLE_W-1:0] hist_q [AVG_TAPS-1];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					for (int i = 0; i < AVG_TAPS - 1; i++) hist_q[i] <= '0;
				end else if (shift) begin
					hist_q[0] <= neg;
					for (int i = 1; i < AVG_TAPS - 1; i++) hist_q[i] <= hist_q[i-1];
				end
			end

			always_comb begin
				sum = SUM_W'(neg);
				for (int i = 0; i < AVG_TAPS - 1; i++) sum = sum + SUM_W'(hist_q[i]);
			end
		end else begin : g_nohist
			assign sum = SUM_W'(neg);
		end
	endgenerate

	// divide by the tap count through a reciprocal, truncating toward zero
	assign sum_neg = sum[SUM_W-1];
	assign mag     = sum_neg ? SUM_W'(-sum) : SUM_W'(sum);
	assign prod    = PROD_W'(mag) * PROD_W'(RECIP);
	assign quot    = prod[K +: SAMPLE_W];
	assign mean    = sum_neg ? SAMPLE_W'(-quot) : SAMPLE_W'(quot);

endmodule

/* rtl/core/wgd_eval.sv */
// trend count and range test over the window of means
module wgd_eval import wgd_pkg::*; #(
	parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
	input  logic signed [SAMPLE_W-1:0] win [WINDOW_LEN],
	input  cfg_t                       cfg,
	output logic                       hit
);

	localparam int CNT_W = $clog2(WINDOW_LEN);
	localparam int CMP_W = (CNT_W > TREND_W) ? CNT_W : TREND_W;
	localparam int LVL   = $clog2(WINDOW_LEN);
	localparam int NODES = 1 << LVL;

	logic [WINDOW_LEN-2:0]      mono;
	logic [CNT_W-1:0]           count;
	logic signed [SAMPLE_W-1:0] hi_t [LVL+1][NODES];
	logic signed [SAMPLE_W-1:0] lo_t [LVL+1][NODES];
	logic [SAMPLE_W:0]          span;

	always_comb begin
		for (int i = 0; i < WINDOW_LEN - 1; i++) begin
			mono[i] = cfg.direction ? (win[i+1] < win[i]) : (win[i+1] > win[i]);
		end
	end

	assign count = CNT_W'($countones(mono));

	// max and min tree, spare leaves repeat the oldest entry
	always_comb begin
		for (int l = 0; l <= LVL; l++) begin
			for (int n = 0; n < NODES; n++) begin
				hi_t[l][n] = '0;
				lo_t[l][n] = '0;
			end
		end
		for (int n = 0; n < NODES; n++) begin
			hi_t[0][n] = (n < WINDOW_LEN) ? win[n] : win[0];
			lo_t[0][n] = (n < WINDOW_LEN) ? win[n] : win[0];
		end
		for (int l = 0; l < LVL; l++) begin
			for (int n = 0; n < (NODES >> (l + 1)); n++) begin
				hi_t[l+1][n] = (hi_t[l][2*n+1] > hi_t[l][2*n]) ? hi_t[l][2*n+1] : hi_t[l][2*n];
				lo_t[l+1][n] = (lo_t[l][2*n+1] < lo_t[l][2*n]) ? lo_t[l][2*n+1] : lo_t[l][2*n];
			end
		end
	end

	assign span = (SAMPLE_W+1)'({hi_t[LVL][0][SAMPLE_W-1], hi_t[LVL][0]}
		- {lo_t[LVL][0][SAMPLE_W-1], lo_t[LVL][0]});

	assign hit = (CMP_W'(count) >= CMP_W'(cfg.min_trend_count))
		&& (span > (SAMPLE_W+1)'(cfg.range_threshold));

endmodule

/* rtl/core/wrist_gesture_detector_unit.sv */
// wrist raise / turn detector top level: config, pipeline and window
// an accepted sample is registered in sample_s1, then mean_s2, then the output register
// throughput: one sample per cycle while m_tready does not stall the output, set by the window update and evaluation
// the window is tested while the mean that entered it is held in stage two, and cleared on a detection
// reset: asynchronous active low, clears history, window, pipeline valids and loads
// register defaults (threshold 4000, trend count 9, raise mode)
module wrist_gesture_detector_unit import wgd_pkg::*; #(
	parameter int WINDOW_LEN = WINDOW_LEN_DEF,
	parameter int AVG_TAPS   = AVG_TAPS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [15:0]           s_tdata,  // [15:0] sample
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata,  // [15:0] smoothed
	output logic                  m_tuser   // [0] detected
);

	cfg_t                       cfg_q;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic                       valid_s1;
	logic signed [SAMPLE_W-1:0] mean;
	logic signed [SAMPLE_W-1:0] mean_s2;
	logic                       valid_s2;
	logic signed [SAMPLE_W-1:0] window_q [WINDOW_LEN];
	logic signed [SAMPLE_W-1:0] window_d [WINDOW_LEN];
	logic                       hit;
	logic                       en1, en2, en3, shift, clear;
	logic                       out_valid_q, detected_q;
	logic signed [SAMPLE_W-1:0] smoothed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_threshold <= RANGE_THRESHOLD_RST;
			cfg_q.min_trend_count <= MIN_TREND_COUNT_RST;
			cfg_q.direction       <= DIRECTION_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RANGE_THRESHOLD: cfg_q.range_threshold <= cfg_wdata[THRESH_W-1:0];
				REG_MIN_TREND_COUNT: cfg_q.min_trend_count <= cfg_wdata[TREND_W-1:0];
				REG_DIRECTION:       cfg_q.direction       <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// stall chain from the output back to the input
	assign en3      = !out_valid_q || m_tready;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign s_tready = en1;
	assign shift    = valid_s1 && en2;
	assign clear    = valid_s2 && hit;

	wgd_average #(.AVG_TAPS(AVG_TAPS)) u_average (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_s1),
		.shift  (shift),
		.mean   (mean)
	);

	wgd_eval #(.WINDOW_LEN(WINDOW_LEN)) u_eval (
		.win (window_q),
		.cfg (cfg_q),
		.hit (hit)
	);

	// pending detection clears the window before the next mean shifts in
	always_comb begin
		for (int i = 0; i < WINDOW_LEN; i++) window_d[i] = clear ? '0 : window_q[i];
		if (shift) begin
			for (int i = 0; i < WINDOW_LEN - 1; i++) window_d[i] = clear ? '0 : window_q[i+1];
			window_d[WINDOW_LEN-1] = mean;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < WINDOW_LEN; i++) window_q[i] <= '0;
		end else begin
			if (en1) valid_s1 <= s_tvalid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) out_valid_q <= valid_s2;
			if (shift || (clear && en3)) begin
				for (int i = 0; i < WINDOW_LEN; i++) window_q[i] <= window_d[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && en1) sample_s1 <= s_tdata;
		if (shift) mean_s2 <= mean;
		if (en3 && valid_s2) begin
			detected_q <= hit;
			smoothed_q <= mean_s2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = smoothed_q;
	assign m_tuser  = detected_q;

endmodule
